// ===== hdl/ssd_pkg.sv =====
// Shared types and constants of the serial subframe sync deframer.
package ssd_pkg;

  localparam int WORD_W   = 12;  // data word and sync pattern width
  localparam int SUB_W    = 2;   // subframe number width
  localparam int IDX_W    = 9;   // word counter / word index width
  localparam int BIW_W    = 4;   // bit-in-word counter width
  localparam int WPS_W    = 10;  // words_per_subframe register width
  localparam int CFG_IDX_W = 3;
  localparam int NUM_SUB  = 4;

  localparam logic [BIW_W-1:0] BITS_PER_WORD = BIW_W'(WORD_W);

  localparam logic [WPS_W-1:0]  WPS_RESET   = 10'd256;
  localparam logic [WORD_W-1:0] SYNC1_RESET = 12'h247;
  localparam logic [WORD_W-1:0] SYNC2_RESET = 12'h5B8;
  localparam logic [WORD_W-1:0] SYNC3_RESET = 12'hA47;
  localparam logic [WORD_W-1:0] SYNC4_RESET = 12'hDB8;

  localparam logic [NUM_SUB-1:0] MASK_FULL = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORDS_PER_SUBFRAME = 3'd0,
    REG_SYNC_WORD_ONE      = 3'd1,
    REG_SYNC_WORD_TWO      = 3'd2,
    REG_SYNC_WORD_THREE    = 3'd3,
    REG_SYNC_WORD_FOUR     = 3'd4
  } ssd_reg_t;

endpackage

// ===== hdl/ssd_if.sv =====
// Valid/ready channel interfaces for the serial input and the word output.
interface ssd_in_if
  import ssd_pkg::*;
;
  logic valid;
  logic ready;
  logic serial_bit;

  modport source (output valid, output serial_bit, input ready);
  modport sink   (input valid, input serial_bit, output ready);
endinterface

interface ssd_out_if
  import ssd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic [SUB_W-1:0]  subframe_number;
  logic [IDX_W-1:0]  word_index;
  logic              superframe_done;

  modport source (output valid, output data_word, output subframe_number,
                  output word_index, output superframe_done, input ready);
  modport sink   (input valid, input data_word, input subframe_number,
                  input word_index, input superframe_done, output ready);
endinterface

// ===== hdl/serial_subframe_sync_deframer_core.sv =====
// Serial subframe sync deframer: delay-line look-ahead sync and word capture.
//
// Takes one serial bit per clock and returns each captured 12-bit word about
// one subframe (words_per_subframe * 12 bits) after its bits went in, behind the
// read register and the output register. Each bit costs one write and one read on
// the simple dual-port delay RAM (DELAY_BITS x 1, read-first, registered read); the
// read result feeds a window/counter stage and then the output register. Sustained
// rate is one bit per clock as long as words are taken; a stalled output holds
// only the next bit that ends a word. No clearing pass: after reset a fill
// flag and the write pointer mark unwritten delay entries, which read as zero.
module serial_subframe_sync_deframer_core
  import ssd_pkg::*;
#(
  parameter int MAX_WORDS  = 512,
  parameter int DELAY_BITS = 6144
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ssd_in_if.sink               in_chan,
  ssd_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  localparam int LMAX_RAW = (MAX_WORDS < DELAY_BITS / 12) ? MAX_WORDS : DELAY_BITS / 12;
  localparam int LMAX     = (LMAX_RAW < 1) ? 1 : LMAX_RAW;
  localparam int LEN_RAW  = $clog2(LMAX + 1);
  localparam int LEN_W    = (LEN_RAW > WPS_W) ? LEN_RAW : WPS_W;
  localparam int PTR_W    = $clog2(DELAY_BITS);
  localparam int AW       = PTR_W + 1;

  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(LMAX);
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
  localparam logic [AW-1:0]    DEPTH_A  = AW'(DELAY_BITS);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DELAY_BITS - 1);
  localparam logic [IDX_W-1:0] WC_ONE   = IDX_W'(1);

  // configuration
  logic [WPS_W-1:0]  wps_r;
  logic [WORD_W-1:0] sync_r [NUM_SUB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wps_r     <= WPS_RESET;
      sync_r[0] <= SYNC1_RESET;
      sync_r[1] <= SYNC2_RESET;
      sync_r[2] <= SYNC3_RESET;
      sync_r[3] <= SYNC4_RESET;
    end else if (cfg_we) begin
      unique case (ssd_reg_t'(cfg_index))
        REG_WORDS_PER_SUBFRAME: wps_r     <= cfg_wdata[WPS_W-1:0];
        REG_SYNC_WORD_ONE:      sync_r[0] <= cfg_wdata;
        REG_SYNC_WORD_TWO:      sync_r[1] <= cfg_wdata;
        REG_SYNC_WORD_THREE:    sync_r[2] <= cfg_wdata;
        REG_SYNC_WORD_FOUR:     sync_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // subframe length, clamped, and delay distance in bits
  logic [LEN_W-1:0]   wps_ext;
  logic [LEN_W-1:0]   len;
  logic [LEN_W+3:0]   dist_full;
  logic [AW-1:0]      dly_dist;

  always_comb begin
    wps_ext = LEN_W'(wps_r);
    if (wps_ext == '0)          len = LEN_ONE;
    else if (wps_ext > LEN_MAX) len = LEN_MAX;
    else                        len = wps_ext;
    dist_full = {1'b0, len, 3'b000} + {2'b00, len, 2'b00};
    dly_dist  = AW'(dist_full);
  end

  // delay line
  logic             mem [DELAY_BITS];
  logic [PTR_W-1:0] wp_r;
  logic             full_r;
  logic [AW-1:0]    wp_ext;
  logic [AW-1:0]    rd_sum;
  logic [PTR_W-1:0] rd_addr;
  logic             rd_ok;
  logic             rd_bit_r;
  logic             rd_ok_r;
  logic             s1_bit_r;
  logic             in_fire;

  always_comb begin
    wp_ext = AW'(wp_r);
    if (wp_ext >= dly_dist) rd_sum = wp_ext - dly_dist;
    else                    rd_sum = wp_ext + DEPTH_A - dly_dist;
    rd_addr = rd_sum[PTR_W-1:0];
    // entries past the write pointer are unwritten until the first wrap
    rd_ok   = full_r || (rd_addr < wp_r);
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_bit_r     <= mem[rd_addr];
      mem[wp_r]    <= in_chan.serial_bit;
      rd_ok_r      <= rd_ok;
      s1_bit_r     <= in_chan.serial_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (in_fire) begin
      if (wp_r == PTR_LAST) begin
        wp_r   <= '0;
        full_r <= 1'b1;
      end else begin
        wp_r <= wp_r + PTR_W'(1);
      end
    end
  end

  // window and capture stage
  logic                s1_valid_r;
  logic [WORD_W-1:0]   live_r, del_r;
  logic [BIW_W-1:0]    biw_r;
  logic [IDX_W-1:0]    wc_r;
  logic                cap_r;
  logic [SUB_W-1:0]    cs_r;
  logic [NUM_SUB-1:0]  mask_r;

  logic [WORD_W-1:0]   live_n, del_n;
  logic [BIW_W-1:0]    biw_n;
  logic [IDX_W-1:0]    wc_n;
  logic                cap_n;
  logic [SUB_W-1:0]    cs_n;
  logic [NUM_SUB-1:0]  mask_n;
  logic                emit;
  logic                done;
  logic [NUM_SUB-1:0]  hit;
  logic                s1_go;
  logic                s1_fire;

  logic                out_valid_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [SUB_W-1:0]    out_sub_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic                out_done_r;

  always_comb begin
    live_n = {s1_bit_r, live_r[WORD_W-1:1]};
    del_n  = {rd_bit_r & rd_ok_r, del_r[WORD_W-1:1]};
    biw_n  = biw_r;
    wc_n   = wc_r;
    cap_n  = cap_r;
    cs_n   = cs_r;
    mask_n = mask_r;
    emit   = 1'b0;
    done   = 1'b0;
    if (cap_r) begin
      biw_n = biw_r + BIW_W'(1);
      if (biw_n == BITS_PER_WORD) begin
        emit  = 1'b1;
        biw_n = '0;
        wc_n  = wc_r + WC_ONE;
      end
      if (wc_n == IDX_W'(len)) begin
        wc_n  = WC_ONE;
        cap_n = 1'b0;
        if (mask_r == MASK_FULL) begin
          done   = 1'b1;
          mask_n = '0;
        end
      end
    end
    for (int k = 0; k < NUM_SUB; k++) begin
      hit[k] = (del_n == sync_r[k]) && (live_n == sync_r[(k + 1) % NUM_SUB]);
    end
    // sync 1 restarts the superframe mask
    if (hit[0]) mask_n = '0;
    for (int k = 0; k < NUM_SUB; k++) begin
      if (hit[k]) begin
        cap_n     = 1'b1;
        cs_n      = SUB_W'(k);
        mask_n[k] = 1'b1;
        biw_n     = '0;
      end
    end
  end

  // hold the stage only when it ends a word and the output slot is taken
  assign s1_go         = !emit || !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && s1_go;
  assign in_chan.ready = !s1_valid_r || s1_go;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      live_r     <= '0;
      del_r      <= '0;
      biw_r      <= '0;
      wc_r       <= WC_ONE;
      cap_r      <= 1'b0;
      cs_r       <= '0;
      mask_r     <= '0;
    end else begin
      if (in_fire)      s1_valid_r <= 1'b1;
      else if (s1_fire) s1_valid_r <= 1'b0;
      if (s1_fire) begin
        live_r <= live_n;
        del_r  <= del_n;
        biw_r  <= biw_n;
        wc_r   <= wc_n;
        cap_r  <= cap_n;
        cs_r   <= cs_n;
        mask_r <= mask_n;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_word_r <= del_n;
      out_sub_r  <= cs_r;
      out_idx_r  <= wc_r;
      out_done_r <= done;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.data_word       = out_word_r;
  assign out_chan.subframe_number = out_sub_r;
  assign out_chan.word_index      = out_idx_r;
  assign out_chan.superframe_done = out_done_r;

endmodule

// ===== hdl/ssd_checker.sv =====
// Port-level checks of the deframer core, bound to the top level.
module ssd_checker
  import ssd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] data_word,
  input logic [SUB_W-1:0]  subframe_number,
  input logic [IDX_W-1:0]  word_index,
  input logic              superframe_done
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_word) &&
    $stable(subframe_number) && $stable(word_index) && $stable(superframe_done))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // with the output slot empty the input side never stalls
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output slot");

endmodule

bind serial_subframe_sync_deframer_core ssd_checker u_ssd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .data_word       (out_chan.data_word),
  .subframe_number (out_chan.subframe_number),
  .word_index      (out_chan.word_index),
  .superframe_done (out_chan.superframe_done)
);

// ===== tb/tb_top.sv =====
// Testbench for the serial subframe sync deframer: directed and random bit streams.
module tb_top;
  import ssd_pkg::*;

  localparam int DLY_DEPTH     = 6144;
  localparam int MAX_LEN       = 512;
  localparam int LEN_CAP       = (DLY_DEPTH / WORD_W < MAX_LEN) ? DLY_DEPTH / WORD_W : MAX_LEN;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic [SUB_W-1:0]  subframe_number;
    logic [IDX_W-1:0]  word_index;
    logic              superframe_done;
  } frame_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;

  ssd_in_if  in_chan ();
  ssd_out_if out_chan ();

  serial_subframe_sync_deframer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Deframer mirror: configuration, delay line, windows and capture state
  logic [WPS_W-1:0]  len_reg;
  logic [WORD_W-1:0] sync_pat [NUM_SUB];
  bit                dly_line [DLY_DEPTH];
  int                wr_ptr;
  logic [WORD_W-1:0] live_win;
  logic [WORD_W-1:0] dly_win;
  logic [BIW_W-1:0]  bit_cnt;
  logic [IDX_W-1:0]  word_cnt;
  logic              capt;
  logic [SUB_W-1:0]  cur_sub;
  logic [NUM_SUB-1:0] sub_mask;

  frame_word_t expected_words [$];

  int error_count  = 0;
  int bits_sent    = 0;
  int words_seen   = 0;
  int sframes_seen = 0;
  int src_idle_pct = 24;
  int snk_idle_pct = 52;
  int rx_hold_req  = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  function automatic void reset_deframer_model();
    len_reg     = WPS_RESET;
    sync_pat[0] = SYNC1_RESET;
    sync_pat[1] = SYNC2_RESET;
    sync_pat[2] = SYNC3_RESET;
    sync_pat[3] = SYNC4_RESET;
    foreach (dly_line[i]) dly_line[i] = 1'b0;
    wr_ptr   = 0;
    live_win = '0;
    dly_win  = '0;
    bit_cnt  = '0;
    word_cnt = IDX_W'(1);
    capt     = 1'b0;
    cur_sub  = '0;
    sub_mask = '0;
  endfunction

  function automatic int subframe_len();
    int len;
    len = int'(len_reg);
    if (len < 1) len = 1;
    if (len > LEN_CAP) len = LEN_CAP;
    return len;
  endfunction

  function automatic void lock_subframe(int k);
    capt        = 1'b1;
    cur_sub     = SUB_W'(k);
    sub_mask[k] = 1'b1;
    bit_cnt     = '0;
  endfunction

  function automatic void apply_reg(ssd_reg_t r, logic [WORD_W-1:0] v);
    case (r)
      REG_WORDS_PER_SUBFRAME: len_reg = v[WPS_W-1:0];
      REG_SYNC_WORD_ONE:      sync_pat[0] = v;
      REG_SYNC_WORD_TWO:      sync_pat[1] = v;
      REG_SYNC_WORD_THREE:    sync_pat[2] = v;
      REG_SYNC_WORD_FOUR:     sync_pat[3] = v;
      default: ;
    endcase
  endfunction

  // Advance the mirror by one serial bit and queue the word it completes, if any
  function automatic void predict_deframed_word(logic b);
    int          len;
    int          rd;
    logic        old_bit;
    bit          emitted;
    bit          sf_done;
    frame_word_t w;
    len     = subframe_len();
    rd      = (wr_ptr + DLY_DEPTH - len * WORD_W) % DLY_DEPTH;
    old_bit = dly_line[rd];
    dly_line[wr_ptr] = b;
    wr_ptr   = (wr_ptr + 1) % DLY_DEPTH;
    live_win = {b, live_win[WORD_W-1:1]};
    dly_win  = {old_bit, dly_win[WORD_W-1:1]};
    emitted  = 1'b0;
    sf_done  = 1'b0;
    w        = '0;
    if (capt) begin
      bit_cnt = bit_cnt + 1'b1;
      if (bit_cnt == BITS_PER_WORD) begin
        emitted           = 1'b1;
        w.data_word       = dly_win;
        w.word_index      = word_cnt;
        w.subframe_number = cur_sub;
        bit_cnt           = '0;
        word_cnt          = word_cnt + 1'b1;
      end
      // Compare modulo the counter width: a 512-word subframe ends when it wraps to zero
      if (word_cnt == IDX_W'(len)) begin
        word_cnt = IDX_W'(1);
        capt     = 1'b0;
        if (sub_mask == MASK_FULL) begin
          sf_done  = 1'b1;
          sub_mask = '0;
        end
      end
    end
    if (dly_win == sync_pat[0] && live_win == sync_pat[1]) begin
      sub_mask = '0;
      lock_subframe(0);
    end
    // Later matches win when patterns are equal
    for (int k = 1; k < NUM_SUB; k++) begin
      if (dly_win == sync_pat[k] && live_win == sync_pat[(k + 1) % NUM_SUB])
        lock_subframe(k);
    end
    if (emitted) begin
      w.superframe_done = sf_done;
      expected_words.push_back(w);
    end
  endfunction

  task automatic write_reg(ssd_reg_t r, logic [WORD_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    apply_reg(r, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_length(logic [WORD_W-1:0] v);
    write_reg(REG_WORDS_PER_SUBFRAME, v);
  endtask

  task automatic set_patterns(logic [WORD_W-1:0] p1, logic [WORD_W-1:0] p2,
                              logic [WORD_W-1:0] p3, logic [WORD_W-1:0] p4);
    write_reg(REG_SYNC_WORD_ONE, p1);
    write_reg(REG_SYNC_WORD_TWO, p2);
    write_reg(REG_SYNC_WORD_THREE, p3);
    write_reg(REG_SYNC_WORD_FOUR, p4);
  endtask

  task automatic send_bit(logic b);
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.serial_bit <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_deframed_word(b);
    bits_sent++;
  endtask

  // Words go out LSB first so the first bit lands at window bit 0
  task automatic send_word(logic [WORD_W-1:0] w);
    for (int i = 0; i < WORD_W; i++) send_bit(w[i]);
  endtask

  task automatic send_random_words(int n);
    repeat (n) send_word(WORD_W'($urandom_range(0, 4095)));
  endtask

  task automatic send_noise(int n);
    repeat (n) send_bit(1'($urandom_range(0, 1)));
  endtask

  // Four headed subframes; a set bit in corrupt flips one bit of that header
  task automatic send_superframe(logic [NUM_SUB-1:0] corrupt);
    int                len;
    int                pos;
    logic [WORD_W-1:0] w;
    len = subframe_len();
    for (int k = 0; k < NUM_SUB; k++) begin
      w = sync_pat[k];
      if (corrupt[k]) begin
        pos    = $urandom_range(0, WORD_W - 1);
        w[pos] = ~w[pos];
      end
      send_word(w);
      send_random_words(len - 1);
    end
  endtask

  // Trailing header confirms subframe four; its words then flush out of the delay
  task automatic close_superframes();
    send_word(sync_pat[0]);
    send_random_words(subframe_len() - 1);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_patterns();
    set_length(12'd2);
    send_superframe('0);
    close_superframes();
    drain_results();
  endtask

  // Zero saturates to one word: captures end without emitting a word
  task automatic test_shortest_subframe();
    set_length(12'hC00);
    send_superframe('0);
    close_superframes();
    drain_results();
  endtask

  task automatic test_equal_patterns();
    set_length(12'd3);
    set_patterns(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    repeat (16) send_bit(1'b1);
    send_random_words(4);
    repeat (16) send_bit(1'b1);
    drain_results();
    set_patterns(12'h000, 12'h000, 12'h000, 12'h000);
    repeat (16) send_bit(1'b0);
    send_random_words(4);
    repeat (16) send_bit(1'b0);
    drain_results();
  endtask

  task automatic test_custom_patterns();
    set_patterns(12'h5A3, 12'h1C6, 12'hE39, 12'h2D4);
    set_length(12'd3);
    send_superframe('0);
    close_superframes();
    drain_results();
  endtask

  // Shorten the subframe while a capture is open: it ends on a bit that completes no word
  task automatic test_length_drop_mid_capture();
    set_length(12'd8);
    send_word(sync_pat[0]);
    send_random_words(7);
    send_word(sync_pat[1]);
    send_random_words(1);
    drain_results();
    set_length(12'd2);
    send_random_words(3);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    set_length(12'd2);
    rx_hold_req = HOLD_CYCLES;
    send_superframe('0);
    close_superframes();
    drain_results();
  endtask

  task automatic random_chunk();
    int                p;
    logic [WORD_W-1:0] len_val;
    drain_results();
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 99) < 15)
        set_patterns(SYNC1_RESET, SYNC2_RESET, SYNC3_RESET, SYNC4_RESET);
      else
        set_patterns(WORD_W'($urandom_range(0, 4095)), WORD_W'($urandom_range(0, 4095)),
                     WORD_W'($urandom_range(0, 4095)), WORD_W'($urandom_range(0, 4095)));
    end
    if ($urandom_range(0, 99) < 60) begin
      p = $urandom_range(0, 99);
      if (p < 8)
        len_val = WORD_W'($urandom_range(0, 1));
      else
        len_val = WORD_W'($urandom_range(2, 3));
      // Upper data bits beyond the register width are don't-care
      len_val[WORD_W-1:WPS_W] = 2'($urandom_range(0, 3));
      set_length(len_val);
    end
    if ($urandom_range(0, 99) < 15) begin
      send_noise($urandom_range(30, 80));
    end else begin
      send_noise($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 20)
        send_superframe(NUM_SUB'($urandom_range(1, 15)));
      else
        send_superframe('0);
      close_superframes();
    end
  endtask

  task automatic test_random_traffic();
    int target;
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin src_idle_pct = 24; snk_idle_pct = 52; end
        1: begin src_idle_pct = 52; snk_idle_pct = 24; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      target = bits_sent + 100;
      while (bits_sent < target) random_chunk();
    end
    drain_results();
  endtask

  // Receiver: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      hold_left   = rx_hold_req;
      rx_hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Compare each output transfer with the oldest predicted word
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      frame_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected word: data_word %0h word_index %0d",
               out_chan.data_word, out_chan.word_index);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        words_seen++;
        if (out_chan.data_word !== want.data_word) begin
          $error("data_word: expected %0h, actual %0h", want.data_word, out_chan.data_word);
          error_count++;
        end
        if (out_chan.subframe_number !== want.subframe_number) begin
          $error("subframe_number: expected %0d, actual %0d",
                 want.subframe_number, out_chan.subframe_number);
          error_count++;
        end
        if (out_chan.word_index !== want.word_index) begin
          $error("word_index: expected %0d, actual %0d", want.word_index, out_chan.word_index);
          error_count++;
        end
        if (out_chan.superframe_done !== want.superframe_done) begin
          $error("superframe_done: expected %0b, actual %0b",
                 want.superframe_done, out_chan.superframe_done);
          error_count++;
        end else if (want.superframe_done) begin
          sframes_seen++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("tb_top: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_WORDS_PER_SUBFRAME;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.serial_bit = 1'b0;
    out_chan.ready     = 1'b0;
    reset_deframer_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_patterns();
    test_shortest_subframe();
    test_equal_patterns();
    test_custom_patterns();
    test_length_drop_mid_capture();
    test_output_backpressure();
    test_random_traffic();

    $display("tb_top: %0d serial bits sent, %0d words checked, %0d superframe ends flagged",
             bits_sent, words_seen, sframes_seen);
    $display("tb_top: subframes of 1 to 8 words, equal, custom and default sync patterns, stalls");
    if (error_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ssd_pkg.sv
hdl/ssd_if.sv
hdl/serial_subframe_sync_deframer_core.sv
hdl/ssd_checker.sv
tb/tb_top.sv
